/* sv/tridiagonal_system_solver_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_CORE_MACROS_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, disabled while reset is held.
`define TSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* sv/tss_pkg.sv */
// Shared types, constants and fixed-point helpers of the tridiagonal solver.
`timescale 1ns / 1ps
package tss_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = 6;
    localparam int DATA_W   = 32;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] diagonal;
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] right_side;
        logic [ROW_W-1:0]         idx;
        logic                     fin;
    } row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_START,
        ST_F_DIV,
        ST_F_MULA,
        ST_F_MULB,
        ST_F_SUB,
        ST_F_WR,
        ST_B_RD,
        ST_B_MUL,
        ST_B_SUB,
        ST_B_START,
        ST_B_DIV,
        ST_B_OUT
    } state_t;

    // Round a raw Q32.32 product back to Q16.16, ties toward +inf, saturate.
    function automatic logic signed [DATA_W-1:0] qmul_fix(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [48:0] f;
        s = {p[63], p} + 65'sh8000;
        f = s[64:16];
        if (f > 49'sh0_7FFF_FFFF) begin
            return Q_MAX;
        end else if (f < -49'sh0_8000_0000) begin
            return Q_MIN;
        end
        return f[DATA_W-1:0];
    endfunction

    // Saturating difference.
    function automatic logic signed [DATA_W-1:0] qsub_fix(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d > 33'sh0_7FFF_FFFF) begin
            return Q_MAX;
        end else if (d < -33'sh0_8000_0000) begin
            return Q_MIN;
        end
        return d[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] abs_fix(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* sv/tss_front.sv */
// Front end: takes row beats, numbers them and flags the row that ends a system.
`timescale 1ns / 1ps
module tss_front import tss_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    input  logic         q_full,
    output logic         q_push,
    output row_t         q_row
);

    logic [ROW_W-1:0] cnt_reg, cnt_next;
    logic             fin;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    // A full store closes the system whatever tlast says.
    assign fin      = s_tlast || (cnt_reg == ROW_W'(MAX_ROWS - 1));

    always_comb begin
        q_row.diagonal   = s_tdata[31:0];
        q_row.upper      = s_tdata[63:32];
        q_row.lower      = s_tdata[95:64];
        q_row.right_side = s_tdata[127:96];
        q_row.idx        = cnt_reg;
        q_row.fin        = fin;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            cnt_next = fin ? '0 : cnt_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* sv/tss_fifo.sv */
// Two-entry row queue between front end and solver engine.
`timescale 1ns / 1ps
module tss_fifo import tss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  row_t push_row,
    output logic full,
    input  logic pop,
    output logic valid,
    output row_t pop_row
);

    row_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign pop_row = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/tss_div.sv */
// Radix-2 restoring divider: saturated (num * 2^16) / den, zero on a zero divisor.
`timescale 1ns / 1ps
module tss_div import tss_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] quo
);

    localparam int QW = DATA_W + 16;

    logic                     busy_reg;
    logic                     done_reg;
    logic [5:0]               cnt_reg;
    logic [DATA_W:0]          rem_reg;
    logic [QW-1:0]            q_reg;
    logic [DATA_W-1:0]        dvs_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [DATA_W:0]          trial;
    logic                     ge;
    logic [DATA_W:0]          rem_next;
    logic [QW-1:0]            q_next;
    logic signed [DATA_W-1:0] sat_q;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb begin
        trial    = {rem_reg[DATA_W-1:0], q_reg[QW-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? trial - {1'b0, dvs_reg} : trial;
        q_next   = {q_reg[QW-2:0], ge};
        if (neg_reg) begin
            sat_q = (q_next > QW'(33'h0_8000_0000)) ? Q_MIN : ~q_next[DATA_W-1:0] + 32'd1;
        end else begin
            sat_q = (q_next > QW'(33'h0_7FFF_FFFF)) ? Q_MAX : q_next[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= 6'(QW - 1);
            rem_reg <= '0;
            q_reg   <= {abs_fix(num), 16'h0};
            dvs_reg <= abs_fix(den);
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            if (den == '0) begin
                quo_reg <= '0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == 6'd0) begin
                quo_reg <= sat_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
            end else if (busy_reg && cnt_reg == 6'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

/* sv/tss_back.sv */
// Solver engine: forward sweep per row, back substitution after the final row.
`timescale 1ns / 1ps
module tss_back import tss_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  row_t                     q_row,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_solution,
    output logic [ROW_W-1:0]         m_row_index,
    output logic                     m_last,
    output logic                     m_singular
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] piv_mem [MAX_ROWS];
    logic [DATA_W-1:0] up_mem  [MAX_ROWS];
    logic [DATA_W-1:0] fwd_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] piv_rd_reg, up_rd_reg, fwd_rd_reg;

    row_t                     row_reg;
    logic signed [DATA_W-1:0] prev_piv_reg, prev_up_reg, prev_fwd_reg;
    logic signed [DATA_W-1:0] l_reg, piv_reg, fwd_reg, t_reg, x_reg;
    logic signed [63:0]       prod_reg;
    logic [ROW_W-1:0]         r_reg;
    logic                     first_reg;
    logic                     zps_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] sol_reg;
    logic [ROW_W-1:0]         ridx_reg;
    logic                     last_reg, sing_reg;

    logic                     div_start, div_done, mem_we, out_load, out_free;
    logic signed [DATA_W-1:0] div_num, div_den, div_quo, mul_a, mul_b, qm;

    tss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign out_free    = !m_valid_reg || m_ready;
    assign qm          = qmul_fix(prod_reg);
    assign m_valid     = m_valid_reg;
    assign m_solution  = sol_reg;
    assign m_row_index = ridx_reg;
    assign m_last      = last_reg;
    assign m_singular  = sing_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (q_valid) begin
                            state_next = (q_row.idx == '0) ? ST_F_WR : ST_F_START;
                        end
            ST_F_START: state_next = ST_F_DIV;
            ST_F_DIV:   if (div_done) begin
                            state_next = ST_F_MULA;
                        end
            ST_F_MULA:  state_next = ST_F_MULB;
            ST_F_MULB:  state_next = ST_F_SUB;
            ST_F_SUB:   state_next = ST_F_WR;
            ST_F_WR:    state_next = row_reg.fin ? ST_B_RD : ST_IDLE;
            ST_B_RD:    state_next = ST_B_MUL;
            ST_B_MUL:   state_next = ST_B_SUB;
            ST_B_SUB:   state_next = ST_B_START;
            ST_B_START: state_next = ST_B_DIV;
            ST_B_DIV:   if (div_done) begin
                            state_next = ST_B_OUT;
                        end
            ST_B_OUT:   if (out_free) begin
                            state_next = (r_reg == '0) ? ST_IDLE : ST_B_RD;
                        end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = row_reg.lower;
        div_den   = prev_piv_reg;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        mul_a     = l_reg;
        mul_b     = prev_up_reg;
        case (state_reg)
            ST_IDLE:    q_pop = q_valid;
            ST_F_START: div_start = 1'b1;
            ST_F_MULB:  mul_b = prev_fwd_reg;
            ST_F_WR:    mem_we = 1'b1;
            ST_B_MUL: begin
                mul_a = up_rd_reg;
                mul_b = x_reg;
            end
            ST_B_START: begin
                div_start = 1'b1;
                div_num   = t_reg;
                div_den   = piv_rd_reg;
            end
            ST_B_OUT:   out_load = out_free;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            piv_mem[row_reg.idx] <= piv_reg;
            up_mem[row_reg.idx]  <= row_reg.upper;
            fwd_mem[row_reg.idx] <= fwd_reg;
        end
        piv_rd_reg <= piv_mem[r_reg];
        up_rd_reg  <= up_mem[r_reg];
        fwd_rd_reg <= fwd_mem[r_reg];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (q_pop) begin
            row_reg <= q_row;
            piv_reg <= q_row.diagonal;
            fwd_reg <= q_row.right_side;
        end
        if (state_reg == ST_F_DIV && div_done) begin
            l_reg <= div_quo;
        end
        if (state_reg == ST_F_MULB) begin
            piv_reg <= qsub_fix(row_reg.diagonal, qm);
        end
        if (state_reg == ST_F_SUB) begin
            fwd_reg <= qsub_fix(row_reg.right_side, qm);
        end
        if (state_reg == ST_F_WR) begin
            prev_piv_reg <= piv_reg;
            prev_up_reg  <= row_reg.upper;
            prev_fwd_reg <= fwd_reg;
            r_reg        <= row_reg.idx;
            first_reg    <= 1'b1;
        end
        if (state_reg == ST_B_SUB) begin
            t_reg <= first_reg ? fwd_rd_reg : qsub_fix(fwd_rd_reg, qm);
        end
        if (state_reg == ST_B_DIV && div_done) begin
            x_reg <= div_quo;
        end
        if (out_load) begin
            sol_reg   <= zps_reg ? '0 : x_reg;
            ridx_reg  <= r_reg;
            last_reg  <= (r_reg == '0);
            sing_reg  <= zps_reg;
            r_reg     <= r_reg - ROW_W'(1);
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            zps_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_F_WR && piv_reg == '0) begin
                zps_reg <= 1'b1;
            end else if (out_load && r_reg == '0) begin
                zps_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/tridiagonal_system_solver_core.sv */
// Top level of the Thomas-algorithm tridiagonal solver, Q16.16 fixed point.
//
//  Channel  Dir  Beat contents
//  s_       in   one matrix row: diagonal, upper, lower, right side; tlast = final row
//  m_       out  one unknown, last row first; tuser = row index and singular flag
//
// Each row after row 0 waits on one pass of the 48-step radix-2 divider that forms
// the row multiplier; row 0 skips the divider. The final row then spends one divider
// pass per unknown in back substitution, plus any time the result register waits
// on m_tready. Reset is synchronous and clears the row count, the singular flag,
// the queue and the output valid flag; the stores need no clearing. A two-row queue
// lets the front end keep accepting while the engine works.
`timescale 1ns / 1ps
module tridiagonal_system_solver_core import tss_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // diagonal[31:0], upper[63:32], lower[95:64], right_side[127:96]
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // solution[31:0]
    output logic [31:0]  m_tdata,
    // row_index[5:0], singular[6]
    output logic [6:0]   m_tuser,
    output logic         m_tlast
);

    // front end to queue
    logic q_full, q_push;
    row_t q_in_row;
    // queue to engine
    logic q_valid, q_pop;
    row_t q_out_row;

    logic signed [DATA_W-1:0] solution;
    logic [ROW_W-1:0]         row_index;
    logic                     singular;

    // Number incoming rows and spot the end of each system.
    tss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_row    (q_in_row)
    );

    // Decouple beat acceptance from the long divider passes.
    tss_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_row (q_in_row),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_row  (q_out_row)
    );

    // Forward sweep, row stores and back substitution.
    tss_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_row       (q_out_row),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_solution  (solution),
        .m_row_index (row_index),
        .m_last      (m_tlast),
        .m_singular  (singular)
    );

    assign m_tdata = solution;
    assign m_tuser = {singular, row_index};

endmodule

/* sv/tss_checker.sv */
// Port-level checks on the solver's result stream, bound to the top level.
`timescale 1ns / 1ps
`include "tridiagonal_system_solver_core_macros.svh"
module tss_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic [6:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled result beat holds.
    `TSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // A singular system reports zero for every unknown.
    `TSS_ASSERT_NOW(a_sing_zero, aclk, aresetn, m_tvalid && m_tuser[6], m_tdata == 32'h0)
    // The run ends on row 0 and only there.
    `TSS_ASSERT_NOW(a_last_row0, aclk, aresetn, m_tvalid, m_tlast == (m_tuser[5:0] == 6'd0))

endmodule

bind tridiagonal_system_solver_core tss_checker u_tss_checker (.*);

/* bench/tb_tridiagonal_system_solver_core.sv */
// Self-checking bench for the Thomas-algorithm tridiagonal solver core.
`timescale 1ns / 1ps
module tb_tridiagonal_system_solver_core;
    import tss_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [6:0]   m_tuser;
    logic         m_tlast;

    tridiagonal_system_solver_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // One unknown as it should leave the m_ channel.
    typedef struct {
        logic [31:0] solution;
        logic [5:0]  row_index;
        logic        last;
        logic        singular;
    } unknown_t;

    // One row of the directed table; has_sol marks a typed-in solution for a
    // one-row system (checked on top of the predictor).
    typedef struct {
        logic [31:0] d, u, l, r;
        logic        fin;
        logic        has_sol;
        logic [31:0] sol;
    } row_vec_t;

    localparam int PERIOD = 8;
    localparam longint CYCLE_LIMIT = 3_000_000;

    // Predictor state.
    logic signed [31:0] piv_mem [MAX_ROWS];
    logic signed [31:0] up_mem  [MAX_ROWS];
    logic signed [31:0] fwd_mem [MAX_ROWS];
    int unsigned        rows_held;
    logic               zero_piv;

    unknown_t    pending_unknowns[$];
    logic [31:0] typed_solutions[$];
    int          errors;
    int          systems_solved;
    int          singular_systems;
    int          rows_sent;
    longint      cycle_count;
    bit          quiet;

    initial aclk = 1'b0;
    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat_q(input logic signed [64:0] v);
        if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [64:0] p;
        p = 65'(a) * 65'(b) + 65'sh8000;
        return sat_q(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [64:0] n;
        if (b == 0) return 32'sd0;
        n = 65'(a) <<< 16;
        return sat_q(n / 65'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat_q(65'(a) - 65'(b));
    endfunction

    // Forward sweep for one row; run back substitution on the final row.
    task automatic sweep_row(input logic [31:0] d, u, l, r, input logic fin);
        int unsigned i, n;
        logic signed [31:0] piv, fwd, mult, x, t;
        unknown_t e;
        i = (rows_held >= MAX_ROWS) ? MAX_ROWS - 1 : rows_held;
        if (i == 0) begin
            piv = d;
            fwd = r;
        end else begin
            mult = fx_div(l, piv_mem[i-1]);
            piv  = fx_sub(d, fx_mul(mult, up_mem[i-1]));
            fwd  = fx_sub(r, fx_mul(mult, fwd_mem[i-1]));
        end
        piv_mem[i] = piv;
        up_mem[i]  = u;
        fwd_mem[i] = fwd;
        if (piv == 0) zero_piv = 1'b1;
        rows_held = i + 1;
        if (!fin && rows_held < MAX_ROWS) return;
        n = i + 1;
        x = 0;
        for (int k = 0; k < n; k++) begin
            int r_i;
            r_i = n - 1 - k;
            t = fwd_mem[r_i];
            if (k != 0) t = fx_sub(t, fx_mul(up_mem[r_i], x));
            x = fx_div(t, piv_mem[r_i]);
            e.solution  = zero_piv ? 32'd0 : x;
            e.row_index = r_i[5:0];
            e.last      = (r_i == 0);
            e.singular  = zero_piv;
            pending_unknowns.push_back(e);
        end
        systems_solved++;
        if (zero_piv) singular_systems++;
        rows_held = 0;
        zero_piv = 1'b0;
    endtask

    // Source side: random gap bursts, then present one beat until taken.
    task automatic send_row(input logic [31:0] d, u, l, r, input logic fin);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l, u, d};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sweep_row(d, u, l, r, fin);
        rows_sent++;
        @(negedge aclk);
    endtask

    // Sink side: random stall bursts, otherwise ready.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare every accepted beat with the oldest pending unknown.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_unknowns.size() == 0) begin
                $error("unexpected beat: solution %h row %0d", m_tdata, m_tuser[5:0]);
                errors++;
            end else begin
                unknown_t e;
                e = pending_unknowns.pop_front();
                if (m_tdata !== e.solution) begin
                    $error("solution: expected %h actual %h", e.solution, m_tdata);
                    errors++;
                end
                if (m_tuser[5:0] !== e.row_index) begin
                    $error("row_index: expected %0d actual %0d", e.row_index, m_tuser[5:0]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %b actual %b", e.last, m_tlast);
                    errors++;
                end
                if (m_tuser[6] !== e.singular) begin
                    $error("singular: expected %b actual %b", e.singular, m_tuser[6]);
                    errors++;
                end
                // Typed-in values for the one-row directed systems.
                if (e.last && typed_solutions.size() > 0 && e.row_index == 0) begin
                    logic [31:0] ts;
                    ts = typed_solutions.pop_front();
                    if (ts !== 32'hxxxx_xxxx && m_tdata !== ts) begin
                        $error("solution: expected %h actual %h", ts, m_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    // Random Q16.16 value: mostly modest, sometimes extreme or zero.
    function automatic logic [31:0] rand_q(input bit lean);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return lean ? 32'd0 : $urandom;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // Diagonally heavy value so most systems stay regular.
    function automatic logic [31:0] rand_diag();
        logic [31:0] v;
        v = $urandom_range(32'h0004_0000, 32'h0040_0000);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    row_vec_t directed[] = '{
        // one-row systems: x = r / d
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 1'b1, 1'b1, 32'h0003_0000},
        '{32'h0000_0000, 32'h0, 32'h0, 32'h0005_0000, 1'b1, 1'b1, 32'h0},      // zero pivot
        '{32'h0000_0001, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h0000_0001, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h0001_0000},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0001_0000},
        // three-row regular system
        '{32'h0004_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0004_0000, 32'h0, 32'h0001_0000, 32'h0003_0000, 1'b1, 1'b0, 32'h0},
        // zero pivot in the middle of a system
        '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0},
        // saturating products and differences
        '{32'h0000_0100, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0}
    };

    initial begin
        int   sys_len;
        logic fin;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        errors      = 0;
        rows_held   = 0;
        zero_piv    = 1'b0;
        systems_solved = 0;
        singular_systems = 0;
        rows_sent   = 0;
        cycle_count = 0;
        quiet       = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table.
        foreach (directed[i]) begin
            if (directed[i].has_sol) typed_solutions.push_back(directed[i].sol);
            send_row(directed[i].d, directed[i].u, directed[i].l, directed[i].r,
                     directed[i].fin);
        end

        // Store-full case: 64 rows with tlast low, the last one closes the system.
        for (int k = 0; k < MAX_ROWS; k++)
            send_row(rand_diag(), rand_q(1), rand_q(1), rand_q(0), 1'b0);

        // Random systems: mostly small and regular, some noisy, a few big.
        while (rows_sent < 330) begin
            case ($urandom_range(0, 9))
                0:       sys_len = $urandom_range(20, 40);
                1, 2:    sys_len = 1;
                default: sys_len = $urandom_range(2, 6);
            endcase
            if (rows_sent > 290) quiet = 1;
            for (int k = 0; k < sys_len; k++) begin
                fin = (k == sys_len - 1);
                if ($urandom_range(0, 4) == 0)
                    send_row(rand_q(1), rand_q(0), rand_q(0), rand_q(0), fin);
                else
                    send_row(rand_diag(), rand_q(1), rand_q(1), rand_q(0), fin);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_unknowns.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("sent %0d rows in %0d systems, %0d of them singular",
                 rows_sent, systems_solved, singular_systems);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tss_pkg.sv
sv/tss_front.sv
sv/tss_fifo.sv
sv/tss_div.sv
sv/tss_back.sv
sv/tridiagonal_system_solver_core.sv
sv/tss_checker.sv
bench/tb_tridiagonal_system_solver_core.sv
